// File: design/fct_pkg.sv
package fct_pkg;

    // fixed field widths
    localparam int CFG_W      = 7;
    localparam int FRAME_W    = 31;
    localparam int ITEM_W     = 6;
    localparam int STATUS_W   = 3;
    localparam int LAST_W     = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    localparam int MAX_ITEMS_DEF    = 64;
    localparam int FRAME_WINDOW_DEF = 16;

    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_ITEMS = 3'd1,
        ST_BAD_ITEM = 3'd2,
        ST_DUP      = 3'd3,
        ST_WINDOW   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SLOT,
        S_READ,
        S_UPDATE,
        S_ADVANCE,
        S_CLEAR
    } state_t;

    // in-order pointer control
    typedef struct packed {
        logic clear;
        logic step;
    } ptr_cmd_t;

endpackage

// File: design/frame_completion_tracker_core.sv
// channel  dir  signals                          contents (lsb first)
// cfg      in   cfg_valid/cfg_ready/cfg_data     items_per_frame[6:0]
// s        in   s_tvalid/s_tready/s_tdata/s_tuser frame_number, item_index; tuser = cmd
// m        out  m_tvalid/m_tready/m_tdata        status, frame_done, done_frame, last_in_order
//
// Path from accept: S_CHECK, back to S_IDLE when rejected there, or S_CLEAR for a clear;
// else S_SLOT and S_READ, back to S_IDLE when the frame already finished out of order,
// then S_UPDATE, back to S_IDLE when the request does not finish the next in-order frame,
// and S_ADVANCE when it does, held while the pointer steps over parked frames (up to FRAME_WINDOW-1).
// s_tready is low while a request is in work or a result waits on m.
// rst_n clears the pointer, slot flags and config at once; bitmaps need no clearing.
module frame_completion_tracker_core #(
    parameter int MAX_ITEMS    = fct_pkg::MAX_ITEMS_DEF,
    parameter int FRAME_WINDOW = fct_pkg::FRAME_WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fct_pkg::CFG_W-1:0]          cfg_data,   // items_per_frame
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fct_pkg::IN_DATA_W-1:0]      s_tdata,    // frame_number[30:0], item_index[36:31]
    input  logic                               s_tuser,    // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fct_pkg::OUT_DATA_W-1:0]     m_tdata     // status[2:0], frame_done[3],
                                                           // done_frame[34:4], last_in_order[66:35]
);

    import fct_pkg::*;

    localparam int SW = $clog2(FRAME_WINDOW);
    localparam logic [CFG_W-1:0]   MAX_N = CFG_W'(MAX_ITEMS);
    localparam logic [SW:0]        WIN_S = (SW + 1)'(FRAME_WINDOW);
    localparam logic signed [33:0] WIN_W = 34'(FRAME_WINDOW);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   ipf_reg, ipf_next;
    logic               cmd_reg, cmd_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [ITEM_W-1:0]  item_reg, item_next;
    logic [SW-1:0]      off_reg, off_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [FRAME_WINDOW-1:0] open_reg, open_next;
    logic [FRAME_WINDOW-1:0] fin_reg, fin_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic               out_done_reg, out_done_next;
    logic [FRAME_W-1:0] out_frame_reg, out_frame_next;

    ptr_cmd_t                 ptr_cmd;
    logic signed [LAST_W-1:0] last;
    logic [SW-1:0]            head;

    logic                 wr_en;
    logic [MAX_ITEMS-1:0] rd_data;
    logic [MAX_ITEMS-1:0] bit_vec;
    logic [MAX_ITEMS-1:0] all_vec;
    logic [MAX_ITEMS-1:0] new_bits;
    logic [CFG_W-1:0]     n_eff;
    logic                 item_bad;
    logic                 too_old;
    logic                 too_new;
    logic                 dup_item;
    logic signed [33:0]   frame_s;
    logic signed [33:0]   last_s;
    logic signed [33:0]   frame_gap;
    logic [SW:0]          slot_sum;
    logic [SW:0]          slot_wrap;
    logic                 accept;

    fct_pending_ram #(
        .DEPTH (FRAME_WINDOW),
        .WIDTH (MAX_ITEMS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (new_bits),
        .rd_addr (slot_reg),
        .rd_data (rd_data)
    );

    fct_order_ptr #(
        .FRAME_WINDOW (FRAME_WINDOW)
    ) u_ptr (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ptr_cmd),
        .last  (last),
        .head  (head)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    // last_in_order only moves while a request is in work, so it is stable here
    assign m_tdata   = {5'b0, last, out_frame_reg, out_done_reg, out_status_reg};

    // checks on the captured request
    assign n_eff     = (ipf_reg > MAX_N) ? MAX_N : ipf_reg;
    assign item_bad  = {1'b0, item_reg} >= n_eff;
    assign frame_s   = signed'({3'b0, frame_reg});
    assign last_s    = {{2{last[LAST_W-1]}}, last};
    assign too_old   = frame_s <= last_s;
    assign too_new   = frame_s > (last_s + WIN_W);
    assign frame_gap = frame_s - last_s - 34'sd1;

    assign slot_sum  = {1'b0, head} + {1'b0, off_reg};
    assign slot_wrap = (slot_sum >= WIN_S) ? slot_sum - WIN_S : slot_sum;

    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            bit_vec[i] = (item_reg == ITEM_W'(i));
            all_vec[i] = (CFG_W'(i) < n_eff);
        end
    end

    assign dup_item = open_reg[slot_reg] && ((rd_data & bit_vec) == '0);
    assign new_bits = open_reg[slot_reg] ? (rd_data & ~bit_vec) : (all_vec & ~bit_vec);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (cmd_reg == CMD_CLEAR)
                begin
                    state_next = S_CLEAR;
                end
                else if (ipf_reg == '0 || item_bad || too_old || too_new)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = fin_reg[slot_reg] ? S_IDLE : S_UPDATE;
            end
            S_UPDATE:
            begin
                if (!dup_item && new_bits == '0 && off_reg == '0)
                begin
                    state_next = S_ADVANCE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADVANCE:
            begin
                if (!fin_reg[head])
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        ipf_next        = cfg_valid ? cfg_data : ipf_reg;
        cmd_next        = cmd_reg;
        frame_next      = frame_reg;
        item_next       = item_reg;
        off_next        = off_reg;
        slot_next       = slot_reg;
        open_next       = open_reg;
        fin_next        = fin_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_done_next   = out_done_reg;
        out_frame_next  = out_frame_reg;
        ptr_cmd         = '0;
        wr_en           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = s_tuser;
                    frame_next = s_tdata[FRAME_W-1:0];
                    item_next  = s_tdata[FRAME_W +: ITEM_W];
                end
            end
            S_CHECK:
            begin
                off_next      = frame_gap[SW-1:0];
                out_done_next = 1'b0;
                out_frame_next = '0;
                if (cmd_reg != CMD_CLEAR)
                begin
                    out_valid_next = 1'b1;
                    if (ipf_reg == '0)
                    begin
                        out_status_next = ST_NO_ITEMS;
                    end
                    else if (item_bad)
                    begin
                        out_status_next = ST_BAD_ITEM;
                    end
                    else if (too_old)
                    begin
                        out_status_next = ST_DUP;
                    end
                    else if (too_new)
                    begin
                        out_status_next = ST_WINDOW;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                    end
                end
            end
            S_SLOT:
            begin
                slot_next = slot_wrap[SW-1:0];
            end
            S_READ:
            begin
                if (fin_reg[slot_reg])
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_DUP;
                end
            end
            S_UPDATE:
            begin
                if (dup_item)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_DUP;
                end
                else
                begin
                    wr_en           = 1'b1;
                    open_next[slot_reg] = 1'b1;
                    out_status_next = ST_OK;
                    if (new_bits != '0)
                    begin
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        open_next[slot_reg] = 1'b0;
                        if (off_reg == '0)
                        begin
                            ptr_cmd.step = 1'b1;
                        end
                        else
                        begin
                            // finished ahead of the pointer: park it
                            fin_next[slot_reg] = 1'b1;
                            out_valid_next = 1'b1;
                            out_done_next  = 1'b1;
                            out_frame_next = frame_reg;
                        end
                    end
                end
            end
            S_ADVANCE:
            begin
                if (fin_reg[head])
                begin
                    fin_next[head] = 1'b0;
                    ptr_cmd.step   = 1'b1;
                end
                else
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_done_next   = 1'b1;
                    out_frame_next  = frame_reg;
                end
            end
            S_CLEAR:
            begin
                open_next       = '0;
                fin_next        = '0;
                ptr_cmd.clear   = 1'b1;
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ipf_reg       <= '0;
            open_reg      <= '0;
            fin_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ipf_reg       <= ipf_next;
            open_reg      <= open_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        frame_reg      <= frame_next;
        item_reg       <= item_next;
        off_reg        <= off_next;
        slot_reg       <= slot_next;
        out_status_reg <= out_status_next;
        out_done_reg   <= out_done_next;
        out_frame_reg  <= out_frame_next;
    end

    a_open_fin_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg & fin_reg) == '0)
        else $error("slot both open and finished");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

    a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    a_head_not_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !fin_reg[head])
        else $error("pointer left behind a finished frame");

endmodule

// File: design/fct_pending_ram.sv
module fct_pending_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/fct_order_ptr.sv
module fct_order_ptr #(
    parameter int FRAME_WINDOW = 16,
    localparam int SW = $clog2(FRAME_WINDOW)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fct_pkg::ptr_cmd_t                 cmd,
    output logic signed [fct_pkg::LAST_W-1:0] last,
    output logic [SW-1:0]                     head
);

    import fct_pkg::*;

    localparam logic [SW-1:0] HEAD_MAX = SW'(FRAME_WINDOW - 1);

    logic signed [LAST_W-1:0] last_reg;
    logic signed [LAST_W-1:0] last_next;
    logic [SW-1:0]            head_reg;
    logic [SW-1:0]            head_next;

    // head tracks the slot of frame last+1
    always_comb
    begin
        last_next = last_reg;
        head_next = head_reg;
        if (cmd.clear)
        begin
            last_next = -32'sd1;
            head_next = '0;
        end
        else if (cmd.step)
        begin
            last_next = last_reg + 32'sd1;
            head_next = (head_reg == HEAD_MAX) ? '0 : head_reg + SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= -32'sd1;
            head_reg <= '0;
        end
        else
        begin
            last_reg <= last_next;
            head_reg <= head_next;
        end
    end

    assign last = last_reg;
    assign head = head_reg;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import fct_pkg::*;

    localparam int          WIN          = FRAME_WINDOW_DEF;
    localparam int          ITEM_CAP     = MAX_ITEMS_DEF;
    localparam logic        CMD_REPORT   = 1'b0;
    localparam logic [30:0] FRAME_MAX    = 31'h7FFF_FFFF;
    localparam logic [5:0]  ITEM_MAX     = 6'd63;
    localparam int          PHASE_ITEMS  = 140;
    localparam int          NUM_PHASES   = 14;
    localparam int          HOLD_START   = 2500;
    localparam int          HOLD_LEN     = 400;
    localparam int          QUIET_START  = 6000;
    localparam int          QUIET_LEN    = 4000;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    typedef struct packed {
        status_t            status;
        logic               done;
        logic [30:0]        frame;
        logic signed [31:0] last;
    } completion_t;

    typedef struct packed {
        logic        cmd;
        logic [30:0] frame;
        logic [5:0]  item;
    } report_t;

    typedef struct packed {
        logic        pinned;
        completion_t want;
    } pin_t;

    typedef struct {
        logic        is_cfg;
        logic [6:0]  cfg_val;
        report_t     rpt;
        pin_t        pin;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;   // frame_number, item_index, zero pad
    logic                   s_tuser   = 1'b0; // cmd
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // status, frame_done, done_frame, last_in_order

    // pinned expectation travels alongside the request data
    pin_t                   req_pin   = '0;

    // tracker model state
    logic [63:0]            pend_map [WIN];
    logic [WIN-1:0]         open_flags    = '0;
    logic [WIN-1:0]         waiting_flags = '0;
    longint                 in_order_last = -1;
    logic [6:0]             items_cfg     = '0;

    completion_t            awaited_replies [$];
    dir_row_t               dir_rows [$];
    bit                     mismatch_seen = 1'b0;
    bit                     gaps_on       = 1'b1;
    int unsigned            cycle_cnt     = 0;

    frame_completion_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic completion_t track_report(report_t rq);
        completion_t r;
        longint      f;
        int          n;
        int          slot;
        int          nxt;
        logic [63:0] bit_m;
        logic [63:0] full_m;
        r.status = ST_OK;
        r.done   = 1'b0;
        r.frame  = '0;
        f = longint'(rq.frame);
        if (rq.cmd == CMD_CLEAR)
        begin
            open_flags    = '0;
            waiting_flags = '0;
            in_order_last = -1;
        end
        else if (items_cfg == 0)
            r.status = ST_NO_ITEMS;
        else
        begin
            n = (items_cfg > ITEM_CAP) ? ITEM_CAP : int'(items_cfg);
            slot  = int'(f % WIN);
            bit_m = 64'd1 << rq.item;
            if (int'(rq.item) >= n)
                r.status = ST_BAD_ITEM;
            else if (f <= in_order_last)
                r.status = ST_DUP;
            else if (f > in_order_last + WIN)
                r.status = ST_WINDOW;
            else if (waiting_flags[slot])
                r.status = ST_DUP;
            else if (open_flags[slot] && (pend_map[slot] & bit_m) == 64'd0)
                r.status = ST_DUP;
            else
            begin
                if (!open_flags[slot])
                begin
                    full_m = (n == ITEM_CAP) ? '1 : ((64'd1 << n) - 64'd1);
                    pend_map[slot]   = full_m & ~bit_m;
                    open_flags[slot] = 1'b1;
                end
                else
                    pend_map[slot] = pend_map[slot] & ~bit_m;
                if (pend_map[slot] == 64'd0)
                begin
                    open_flags[slot] = 1'b0;
                    r.done  = 1'b1;
                    r.frame = rq.frame;
                    if (f == in_order_last + 1)
                    begin
                        in_order_last++;
                        // sweep past frames that finished out of order
                        nxt = int'((in_order_last + 1) % WIN);
                        while (waiting_flags[nxt])
                        begin
                            waiting_flags[nxt] = 1'b0;
                            in_order_last++;
                            nxt = int'((in_order_last + 1) % WIN);
                        end
                    end
                    else
                        waiting_flags[slot] = 1'b1;
                end
            end
        end
        r.last = in_order_last[31:0];
        return r;
    endfunction

    // observe the cfg, result and request handshakes; replies are taken before the new request is queued
    always @(posedge clk)
    begin
        completion_t want;
        completion_t got;
        report_t     rq;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                items_cfg = cfg_data;
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tdata[2:0]);
                got.done   = m_tdata[3];
                got.frame  = m_tdata[34:4];
                got.last   = m_tdata[66:35];
                if (awaited_replies.size() == 0)
                begin
                    $error("reply with no request outstanding: %h", m_tdata);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = awaited_replies[0];
                    awaited_replies.delete(0);
                    if (got.status != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatch_seen = 1'b1;
                    end
                    if (got.done != want.done)
                    begin
                        $error("frame_done: expected %0d, got %0d", want.done, got.done);
                        mismatch_seen = 1'b1;
                    end
                    if (got.frame != want.frame)
                    begin
                        $error("done_frame: expected %0d, got %0d", want.frame, got.frame);
                        mismatch_seen = 1'b1;
                    end
                    if (got.last != want.last)
                    begin
                        $error("last_in_order: expected %0d, got %0d",
                               $signed(want.last), $signed(got.last));
                        mismatch_seen = 1'b1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                rq.cmd   = s_tuser;
                rq.frame = s_tdata[30:0];
                rq.item  = s_tdata[36:31];
                want = track_report(rq);
                if (req_pin.pinned)
                    want = req_pin.want;
                awaited_replies.insert(awaited_replies.size(), want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("frame_completion_tracker_core: mismatch");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off, one quiet stretch
    initial
    begin
        int rx_cycle;
        rx_cycle = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else if (rx_cycle >= QUIET_START && rx_cycle < QUIET_START + QUIET_LEN)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 7);
        end
    end

    task automatic send_request(report_t rq, pin_t pin);
        if (gaps_on && $urandom_range(0, 99) < 7)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.cmd;
        s_tdata  <= {3'b000, rq.item, rq.frame};
        req_pin  <= pin;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // drain all replies, then let the block idle before the write
    task automatic write_items_cfg(logic [6:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(dir_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic dir_row_t cfg_row(logic [6:0] value);
        dir_row_t row;
        row.is_cfg  = 1'b1;
        row.cfg_val = value;
        row.rpt     = '0;
        row.pin     = '0;
        return row;
    endfunction

    function automatic dir_row_t req_row(logic cmd, logic [30:0] frame, logic [5:0] item);
        dir_row_t row;
        row.is_cfg  = 1'b0;
        row.cfg_val = '0;
        row.rpt     = '{cmd, frame, item};
        row.pin     = '0;
        return row;
    endfunction

    function automatic dir_row_t pin_row(logic cmd, logic [30:0] frame, logic [5:0] item,
                                         status_t st, logic signed [31:0] last);
        dir_row_t row;
        row = req_row(cmd, frame, item);
        row.pin.pinned      = 1'b1;
        row.pin.want.status = st;
        row.pin.want.done   = 1'b0;
        row.pin.want.frame  = '0;
        row.pin.want.last   = last;
        return row;
    endfunction

    function automatic report_t noise_report(longint base);
        report_t rq;
        longint  f;
        rq.cmd = ($urandom_range(0, 99) < 3) ? CMD_CLEAR : CMD_REPORT;
        if ($urandom_range(0, 99) < 30)
            rq.frame = 31'($urandom() & FRAME_MAX);
        else
        begin
            f = base + longint'($urandom_range(0, 24)) - 4;
            rq.frame = (f < 0) ? 31'd0 : f[30:0];
        end
        rq.item = 6'($urandom_range(0, 63));
        return rq;
    endfunction

    initial
    begin
        report_t     batch [$];
        report_t     tmp;
        logic [6:0]  phase_cfg [NUM_PHASES];
        pin_t        no_pin;
        longint      base;
        int          n_eff;
        int          quota;
        int          sent;
        int          nfr;
        int          offs;
        int          j;
        int          p;

        no_pin = '0;
        phase_cfg = '{7'd3, 7'd1, 7'd2, 7'd5, 7'd64, 7'd8, 7'd127,
                      7'd0, 7'd16, 7'd4, 7'd33, 7'd65, 7'd6, 7'd2};

        add_row(pin_row(CMD_REPORT, 31'd0, 6'd0, ST_NO_ITEMS, -32'sd1));
        add_row(cfg_row(7'd1));
        // single-item frame finishes on its first report
        begin
            dir_row_t row;
            row = pin_row(CMD_REPORT, 31'd0, 6'd0, ST_OK, 32'sd0);
            row.pin.want.done = 1'b1;
            add_row(row);
        end
        add_row(pin_row(CMD_REPORT, 31'd0, 6'd0, ST_DUP, 32'sd0));
        add_row(pin_row(CMD_REPORT, 31'd0, 6'd1, ST_BAD_ITEM, 32'sd0));
        add_row(req_row(CMD_REPORT, 31'd2, 6'd0));
        add_row(req_row(CMD_REPORT, 31'd2, 6'd0));
        add_row(pin_row(CMD_REPORT, 31'd17, 6'd0, ST_WINDOW, 32'sd0));
        add_row(req_row(CMD_REPORT, 31'd16, 6'd0));
        add_row(req_row(CMD_REPORT, 31'd1, 6'd0));
        add_row(pin_row(CMD_REPORT, FRAME_MAX, ITEM_MAX, ST_BAD_ITEM, 32'sd2));
        add_row(pin_row(CMD_CLEAR, FRAME_MAX, ITEM_MAX, ST_OK, -32'sd1));
        add_row(cfg_row(7'd64));
        add_row(req_row(CMD_REPORT, 31'd0, ITEM_MAX));
        add_row(req_row(CMD_REPORT, 31'd0, ITEM_MAX));
        add_row(pin_row(CMD_REPORT, FRAME_MAX, 6'd0, ST_WINDOW, -32'sd1));
        add_row(cfg_row(7'd127));
        add_row(req_row(CMD_REPORT, 31'd15, ITEM_MAX));
        add_row(pin_row(CMD_REPORT, 31'd16, 6'd0, ST_WINDOW, -32'sd1));
        add_row(pin_row(CMD_CLEAR, 31'd0, 6'd0, ST_OK, -32'sd1));
        add_row(cfg_row(7'd2));
        add_row(req_row(CMD_REPORT, 31'd0, 6'd0));
        add_row(req_row(CMD_REPORT, 31'd0, 6'd1));
        add_row(pin_row(CMD_REPORT, 31'd1, 6'd2, ST_BAD_ITEM, 32'sd0));
        add_row(cfg_row(7'd0));
        add_row(pin_row(CMD_REPORT, 31'd5, 6'd0, ST_NO_ITEMS, 32'sd0));
        add_row(pin_row(CMD_CLEAR, 31'd0, 6'd0, ST_OK, -32'sd1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_items_cfg(dir_rows[i].cfg_val);
            else
                send_request(dir_rows[i].rpt, dir_rows[i].pin);
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_items_cfg(phase_cfg[p]);
            n_eff   = (phase_cfg[p] > ITEM_CAP) ? ITEM_CAP : int'(phase_cfg[p]);
            quota   = (n_eff == 0) ? 30 : PHASE_ITEMS;
            gaps_on = (p != 2);
            sent    = 0;
            while (sent < quota)
            begin
                // a few frames in the window, all items of each, in shuffled order
                base = in_order_last + 1;
                batch.delete();
                if (n_eff <= 8)
                    nfr = $urandom_range(2, 8);
                else if (n_eff <= 16)
                    nfr = $urandom_range(1, 3);
                else
                    nfr = 1;
                for (int k = 0; k < nfr && n_eff > 0; k++)
                begin
                    offs = (k == 0 && $urandom_range(0, 99) < 70) ? 0 : $urandom_range(0, 15);
                    for (int it = 0; it < n_eff; it++)
                    begin
                        tmp.cmd   = CMD_REPORT;
                        tmp.frame = 31'(base + offs);
                        tmp.item  = it[5:0];
                        batch.insert(batch.size(), tmp);
                    end
                end
                for (int k = batch.size() - 1; k > 0; k--)
                begin
                    j = $urandom_range(0, k);
                    tmp = batch[k];
                    batch[k] = batch[j];
                    batch[j] = tmp;
                end
                if (n_eff == 0)
                begin
                    send_request(noise_report(base), no_pin);
                    sent++;
                end
                foreach (batch[k])
                begin
                    if (sent >= quota)
                        break;
                    if ($urandom_range(0, 99) < 12)
                    begin
                        send_request(noise_report(in_order_last + 1), no_pin);
                        sent++;
                    end
                    send_request(batch[k], no_pin);
                    sent++;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (!mismatch_seen)
            $display("frame_completion_tracker_core: match");
        else
            $display("frame_completion_tracker_core: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
design/fct_pkg.sv
design/fct_pending_ram.sv
design/fct_order_ptr.sv
design/frame_completion_tracker_core.sv
bench/tb.sv
